// ===== rtl/core/fpts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpts_pkg
// shared widths, codes and defaults of the fixed priority tick scheduler
// ----------------------------------------------------------------------------
package fpts_pkg;
  localparam int MAX_TASKS_DEF     = 16;
  localparam int PENDING_DEPTH_DEF = 4;
  localparam int IDX_W  = 4;
  localparam int TIME_W = 16;
  localparam int PRIO_W = 8;
  localparam int TC_W   = 5;
  localparam logic [TIME_W-1:0] HORIZON_RST = 16'd1000;
  localparam logic [TC_W-1:0]   TASK_COUNT_RST = 5'd1;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IGNORED = 2'd1,
    ST_DROPPED = 2'd2,
    ST_BAD_IDX = 2'd3
  } status_t;

  localparam logic [0:0] CFG_TASK_COUNT = 1'b0;
  localparam logic [0:0] CFG_HORIZON    = 1'b1;
endpackage

// ===== rtl/core/fixed_priority_tick_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_priority_tick_scheduler
// one-tick-per-word preemptive fixed priority scheduler
// ----------------------------------------------------------------------------
// Every word (load, tick or read) is taken whenever start is high; its result shows on
// the out_ ports, with out_valid high, in the cycle after the word is
// accepted; busy is never high, so a word may follow in every cycle. The result
// register is the only stage, set by the per-task release logic and a
// priority select over all task slots. The receiver cannot stall; each result
// is present for one cycle only. Configuration writes are always ready.
module fixed_priority_tick_scheduler #(
  parameter int MAX_TASKS     = fpts_pkg::MAX_TASKS_DEF,
  parameter int PENDING_DEPTH = fpts_pkg::PENDING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [fpts_pkg::IDX_W-1:0]    in_task_index,
  input  logic [fpts_pkg::TIME_W-1:0]   in_task_wcet,
  input  logic [fpts_pkg::TIME_W-1:0]   in_task_period,
  input  logic [fpts_pkg::PRIO_W-1:0]   in_task_priority,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [fpts_pkg::IDX_W-1:0]    out_running_task,
  output logic                          out_idle,
  output logic                          out_job_done,
  output logic [fpts_pkg::TIME_W-1:0]   out_response_time,
  output logic [fpts_pkg::TIME_W-1:0]   out_worst_response,
  output logic                          out_finished,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [0:0]                    cfg_index,
  input  logic [15:0]                   cfg_data
);
  import fpts_pkg::*;

  localparam int PC_W  = $clog2(PENDING_DEPTH + 1);
  localparam int PD_IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int SEL_W = $clog2(MAX_TASKS);
  localparam int NP    = 1 << SEL_W;
  localparam logic [PC_W-1:0] PC_FULL = PC_W'(PENDING_DEPTH);
  localparam logic [PC_W-1:0] PC_ONE  = PC_W'(1);

  typedef logic [TIME_W-1:0] time_t;

  logic [TC_W-1:0]   task_count_r;
  time_t             horizon_r;
  time_t             cur_time_r;
  logic              finished_r, started_r;

  time_t             wcet_r   [MAX_TASKS];
  time_t             period_r [MAX_TASKS];
  logic [PRIO_W-1:0] prio_r   [MAX_TASKS];
  time_t             cdown_r  [MAX_TASKS];
  time_t             rel_r    [MAX_TASKS][PENDING_DEPTH];
  time_t             remain_r [MAX_TASKS];
  logic [PC_W-1:0]   pcount_r [MAX_TASKS];
  time_t             worst_r  [MAX_TASKS];

  logic              valid_r;
  logic [1:0]        status_r;
  logic [IDX_W-1:0]  running_r;
  logic              idle_r, done_r;
  time_t             resp_r, wresp_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_running_task   = running_r;
  assign out_idle           = idle_r;
  assign out_job_done       = done_r;
  assign out_response_time  = resp_r;
  assign out_worst_response = wresp_r;
  assign out_finished       = finished_r;

  wire accept = start && !busy;
  wire idx_ok = (32'(in_task_index) < MAX_TASKS);
  wire [SEL_W-1:0] sel_idx = SEL_W'(in_task_index);

  // slot takes part
  logic active [MAX_TASKS];
  logic any_pend;
  always_comb begin
    any_pend = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      active[i] = (32'(task_count_r) > i);
      if (active[i] && pcount_r[i] != '0) any_pend = 1'b1;
    end
  end

  wire over_now   = (cur_time_r >= horizon_r) || !any_pend;
  wire tick_run   = !finished_r && !over_now;
  wire do_release = (cur_time_r != '0);

  // release phase
  time_t           cd_nxt  [MAX_TASKS];
  logic            rel_ev  [MAX_TASKS];
  logic [PC_W-1:0] pc_rel  [MAX_TASKS];
  time_t           head_t  [MAX_TASKS];
  logic            drop_any;
  always_comb begin
    drop_any = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      cd_nxt[i]   = cdown_r[i];
      rel_ev[i]   = 1'b0;
      pc_rel[i]   = pcount_r[i];
      if (do_release && active[i] && period_r[i] != '0) begin
        cd_nxt[i] = cdown_r[i] - 1'b1;
        if (cd_nxt[i] == '0) begin
          cd_nxt[i] = period_r[i];
          if (wcet_r[i] != '0) begin
            if (pcount_r[i] >= PC_FULL) begin
              drop_any    = 1'b1;
            end else begin
              rel_ev[i] = 1'b1;
              pc_rel[i] = pcount_r[i] + 1'b1;
            end
          end
        end
      end
      head_t[i] = (pcount_r[i] == '0) ? cur_time_r : rel_r[i][0];
    end
  end

  // priority select as a balanced tree, the right (higher) slot wins only
  // when strictly better, so full ties go to the lower index
  logic              nd_v [2*NP];
  logic [PRIO_W-1:0] nd_p [2*NP];
  time_t             nd_h [2*NP];
  logic [SEL_W-1:0]  nd_i [2*NP];
  logic              take_b;
  logic              found;
  logic [SEL_W-1:0]  best;
  always_comb begin
    take_b  = 1'b0;
    nd_v[0] = 1'b0;
    nd_p[0] = '0;
    nd_h[0] = '0;
    nd_i[0] = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      nd_v[NP+i] = active[i] && (pc_rel[i] != '0);
      nd_p[NP+i] = prio_r[i];
      nd_h[NP+i] = head_t[i];
      nd_i[NP+i] = SEL_W'(i);
    end
    for (int i = MAX_TASKS; i < NP; i++) begin
      nd_v[NP+i] = 1'b0;
      nd_p[NP+i] = '0;
      nd_h[NP+i] = '0;
      nd_i[NP+i] = SEL_W'(i);
    end
    for (int n = NP - 1; n >= 1; n--) begin
      take_b = nd_v[2*n+1] && (!nd_v[2*n] || nd_p[2*n+1] < nd_p[2*n] ||
               (nd_p[2*n+1] == nd_p[2*n] && nd_h[2*n+1] < nd_h[2*n]));
      nd_v[n] = nd_v[2*n] || nd_v[2*n+1];
      nd_p[n] = take_b ? nd_p[2*n+1] : nd_p[2*n];
      nd_h[n] = take_b ? nd_h[2*n+1] : nd_h[2*n];
      nd_i[n] = take_b ? nd_i[2*n+1] : nd_i[2*n];
    end
    found = nd_v[1];
    best  = nd_i[1];
  end

  wire time_t time_nxt = cur_time_r + 1'b1;
  wire time_t rem_best = ((pcount_r[best] == '0) ? wcet_r[best] : remain_r[best]) - 1'b1;
  wire        jdone    = found && (rem_best == '0);
  wire time_t resp     = time_nxt - head_t[best];
  wire time_t worst_nx = (resp > worst_r[best]) ? resp : worst_r[best];

  logic any_left;
  always_comb begin
    any_left = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (active[i]) begin
        if (found && jdone && SEL_W'(i) == best) begin
          if (pc_rel[i] != PC_ONE) any_left = 1'b1;
        end else if (pc_rel[i] != '0) begin
          any_left = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= TASK_COUNT_RST;
      horizon_r    <= HORIZON_RST;
      cur_time_r   <= '0;
      finished_r   <= 1'b0;
      started_r    <= 1'b0;
      valid_r      <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        wcet_r[i]   <= '0;
        remain_r[i] <= '0;
        pcount_r[i] <= '0;
        worst_r[i]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TASK_COUNT: task_count_r <= cfg_data[TC_W-1:0];
          CFG_HORIZON:    horizon_r    <= cfg_data;
          default: ;
        endcase
      end
      valid_r <= accept;
      if (accept) begin
        status_r  <= ST_OK;
        running_r <= '0;
        idle_r    <= 1'b0;
        done_r    <= 1'b0;
        resp_r    <= '0;
        wresp_r   <= '0;
        case (func_t'(in_func))
          FUNC_LOAD: begin
            if (!idx_ok) begin
              status_r <= ST_BAD_IDX;
            end else if (started_r) begin
              status_r <= ST_IGNORED;
            end else begin
              wcet_r[sel_idx]    <= in_task_wcet;
              period_r[sel_idx]  <= in_task_period;
              prio_r[sel_idx]    <= in_task_priority;
              cdown_r[sel_idx]   <= in_task_period;
              worst_r[sel_idx]   <= '0;
              rel_r[sel_idx][0]  <= '0;
              remain_r[sel_idx]  <= in_task_wcet;
              pcount_r[sel_idx]  <= PC_W'(in_task_wcet != '0);
            end
          end
          FUNC_READ: begin
            if (!idx_ok) status_r <= ST_BAD_IDX;
            else wresp_r <= worst_r[sel_idx];
          end
          FUNC_TICK: begin
            started_r <= 1'b1;
            if (!tick_run) begin
              finished_r <= 1'b1;
              status_r   <= ST_IGNORED;
            end else begin
              status_r   <= drop_any ? ST_DROPPED : ST_OK;
              cur_time_r <= time_nxt;
              finished_r <= (time_nxt >= horizon_r) || !any_left;
              for (int i = 0; i < MAX_TASKS; i++) begin
                cdown_r[i] <= cd_nxt[i];
                pcount_r[i] <= pc_rel[i];
                if (rel_ev[i]) begin
                  if (pcount_r[i] == '0) remain_r[i] <= wcet_r[i];
                  rel_r[i][pcount_r[i][PD_IW-1:0]] <= cur_time_r;
                end
              end
              if (!found) begin
                idle_r <= 1'b1;
              end else begin
                running_r <= IDX_W'(best);
                remain_r[best] <= rem_best;
                if (jdone) begin
                  done_r        <= 1'b1;
                  resp_r        <= resp;
                  wresp_r       <= worst_nx;
                  worst_r[best] <= worst_nx;
                  for (int k = 1; k < PENDING_DEPTH; k++) begin
                    if (PC_W'(k) < pc_rel[best]) begin
                      if (rel_ev[best] && PC_W'(k) == pcount_r[best])
                        rel_r[best][k-1] <= cur_time_r;
                      else rel_r[best][k-1] <= rel_r[best][k];
                    end
                  end
                  pcount_r[best] <= pc_rel[best] - 1'b1;
                  if (pc_rel[best] != PC_ONE) remain_r[best] <= wcet_r[best];
                end
              end
            end
          end
          default: status_r <= ST_IGNORED;
        endcase
      end
    end
  end
endmodule

// ===== rtl/core/fpts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpts_checker
// port level checks of the tick scheduler
// ----------------------------------------------------------------------------
module fpts_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic       out_idle,
  input logic       out_job_done,
  input logic       out_finished
);
  import fpts_pkg::*;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid) else $error("missing result");
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid) else $error("spurious result");
  a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_idle && out_job_done)) else $error("idle with completion");
  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_finished) && $past(rst_n) |-> out_finished) else $error("finished dropped");
  // a completion only comes from a tick that ran
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_job_done) |-> (out_status != ST_IGNORED && out_status != ST_BAD_IDX))
    else $error("completion on ignored word");
endmodule

bind fixed_priority_tick_scheduler fpts_checker u_fpts_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_status(out_status), .out_idle(out_idle), .out_job_done(out_job_done),
  .out_finished(out_finished)
);
